// File: rtl/core/cctc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cctc_pkg;

  // Queue and timing
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_BITS   = 512;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_SHIFT  = $clog2(SLOT_BITS);

  // Field widths
  localparam int CMD_W   = 3;
  localparam int BYTES_W = 11;
  localparam int TAG_W   = 16;
  localparam int RND_W   = 16;
  localparam int KIND_W  = 2;
  localparam int COLL_W  = 16;
  localparam int TRIES_W = 8;
  localparam int CAP_W   = 4;
  localparam int TRY_W   = TRIES_W + 1;

  localparam int BYTES_MAX = (1 << BYTES_W) - 1;
  localparam int TIMER_MAX = 1 + (BYTES_MAX * 8) / SLOT_BITS;
  localparam int TIMER_W   = $clog2(TIMER_MAX + 1);

  // Config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_CAP = 1'd1;
  localparam logic [TRIES_W-1:0]   MAX_TRIES_RST   = 8'd16;
  localparam logic [CAP_W-1:0]     BACKOFF_CAP_RST = 4'd10;

  // Event codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MSTART = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MDONE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MFAIL  = 3'd4;

  // Media message codes
  localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAIL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
  } q_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
    logic [COLL_W-1:0]  coll;
    logic               last;
  } result_t;

  // Controller -> datapath
  typedef struct packed {
    logic              take_in;
    logic              tick_timer;
    logic              enq;
    logic              set_busy;
    logic              clr_busy;
    logic              try_reset;
    logic              try_inc;
    logic              coll_inc;
    logic              div_start;
    logic              timer_load_rem;
    logic              timer_load_len;
    logic              pop;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
    logic              flush;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fill_zero;
    logic             fill_gt1;
    logic             timer_zero;
    logic             timer_le1;
    logic             busy;
    logic             try_over;
    logic             rem_done;
    logic             emit_ok;
    logic             pend_valid;
    logic             out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/cctc_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface cctc_evt_if;
  import cctc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [BYTES_W-1:0] packet_bytes;
  logic [TAG_W-1:0]   packet_tag;
  logic [RND_W-1:0]   random_value;

  modport source(output valid, command, packet_bytes, packet_tag, random_value,
                 input ready);
  modport sink(input valid, command, packet_bytes, packet_tag, random_value,
               output ready);
endinterface

interface cctc_res_if;
  import cctc_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  media_kind;
  logic [TAG_W-1:0]   out_tag;
  logic [BYTES_W-1:0] out_bytes;
  logic [COLL_W-1:0]  collision_total;
  logic               last;

  modport source(output valid, media_kind, out_tag, out_bytes, collision_total, last,
                 input ready);
  modport sink(input valid, media_kind, out_tag, out_bytes, collision_total, last,
               output ready);
endinterface

`default_nettype wire

// File: rtl/core/cctc_rem_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Remainder of a 16-bit draw by a 4-bit modulus, four dividend bits per cycle.
module cctc_rem_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cctc_pkg::RND_W-1:0] dividend_i,
  input  wire logic [cctc_pkg::CAP_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [cctc_pkg::CAP_W-1:0]      rem_o
);
  import cctc_pkg::*;

  localparam int STEP_BITS = 4;
  localparam int CYCLES    = RND_W / STEP_BITS;
  localparam int CNT_W     = (CYCLES > 1) ? $clog2(CYCLES) : 1;

  logic             busy_q, done_q, zero_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RND_W-1:0] dvd_q;
  logic [CAP_W-1:0] dvs_q, rem_q, rem_d;

  always_comb begin
    logic [CAP_W:0] r5;
    logic [CAP_W-1:0] r;
    r = rem_q;
    for (int k = 0; k < STEP_BITS; k++) begin
      r5 = {r, dvd_q[RND_W-1-k]};
      if (r5 >= {1'b0, dvs_q}) begin
        r5 = r5 - {1'b0, dvs_q};
      end
      r = r5[CAP_W-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
      rem_q  <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << STEP_BITS;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = zero_q ? '0 : rem_q;

endmodule

`default_nettype wire

// File: rtl/core/cctc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cctc_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cctc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cctc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [cctc_pkg::CMD_W-1:0]      evt_cmd_i,
  input  wire logic [cctc_pkg::BYTES_W-1:0]    evt_bytes_i,
  input  wire logic [cctc_pkg::TAG_W-1:0]      evt_tag_i,
  input  wire logic [cctc_pkg::RND_W-1:0]      evt_rnd_i,
  input  wire cctc_pkg::cmd_t                  cmd_i,
  output cctc_pkg::stat_t                      stat_o,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output cctc_pkg::result_t                    out_res_o
);
  import cctc_pkg::*;

  localparam int SUM_W = QPTR_W + 1;

  // Config
  logic [TRIES_W-1:0] max_tries_q;
  logic [CAP_W-1:0]   backoff_cap_q;

  // Latched event
  logic [CMD_W-1:0]   cmd_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [TAG_W-1:0]   tag_q;
  logic [RND_W-1:0]   rnd_q;

  // Transmit state
  logic               busy_q;
  logic [TRY_W-1:0]   try_q;
  logic [TIMER_W-1:0] timer_q;
  logic [COLL_W-1:0]  coll_q;
  logic [QPTR_W-1:0]  head_q, head_d;
  logic [QFILL_W-1:0] fill_q;

  // Packet queue
  q_entry_t           q_mem [QUEUE_DEPTH];
  q_entry_t           head_ent_q, wr_ent;
  logic               wr_en;
  logic [SUM_W-1:0]   slot_sum;
  logic [QPTR_W-1:0]  wr_addr;
  logic               fill_full;

  // Results
  result_t            pend_q, out_q;
  logic               pend_valid_q, out_valid_q, out_free;

  // Backoff modulus
  logic [CAP_W-1:0]   modulus;
  logic               rem_done;
  logic [CAP_W-1:0]   rem_val;
  logic [BYTES_W+2:0] len_bits;
  logic [TIMER_W-1:0] len_slots;

  assign fill_full = (fill_q == QFILL_W'(QUEUE_DEPTH));
  assign slot_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
  assign wr_addr   = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     QPTR_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : QPTR_W'(slot_sum);
  assign wr_en     = cmd_i.enq && !fill_full;
  assign wr_ent    = '{tag: tag_q, bytes: bytes_q};

  always_comb begin
    head_d = head_q;
    if (cmd_i.pop) begin
      head_d = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
    end
  end

  // Head entry is held registered; a write to the next head bypasses the array.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_addr] <= wr_ent;
    end
    head_ent_q <= (wr_en && wr_addr == head_d) ? wr_ent : q_mem[head_d];
  end

  assign modulus   = ({{(TRY_W-CAP_W){1'b0}}, backoff_cap_q} < try_q) ?
                     backoff_cap_q : try_q[CAP_W-1:0];
  assign len_bits  = {head_ent_q.bytes, 3'b000};
  assign len_slots = TIMER_W'(len_bits >> SLOT_SHIFT) + TIMER_W'(1);

  cctc_rem_unit u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(rnd_q),
    .divisor_i (modulus),
    .done_o    (rem_done),
    .rem_o     (rem_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q   <= MAX_TRIES_RST;
      backoff_cap_q <= BACKOFF_CAP_RST;
      busy_q        <= 1'b0;
      try_q         <= TRY_W'(1);
      timer_q       <= '0;
      coll_q        <= '0;
      head_q        <= '0;
      fill_q        <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      cmd_q         <= CMD_TICK;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_TRIES:   max_tries_q   <= cfg_data_i[TRIES_W-1:0];
          CFG_BACKOFF_CAP: backoff_cap_q <= cfg_data_i[CAP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.take_in) begin
        cmd_q <= evt_cmd_i;
      end
      if (cmd_i.set_busy) begin
        busy_q <= 1'b1;
      end else if (cmd_i.clr_busy) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.try_reset) begin
        try_q <= TRY_W'(1);
      end else if (cmd_i.try_inc) begin
        try_q <= try_q + TRY_W'(1);
      end
      if (cmd_i.timer_load_rem) begin
        timer_q <= TIMER_W'(rem_val);
      end else if (cmd_i.timer_load_len) begin
        timer_q <= len_slots;
      end else if (cmd_i.tick_timer && timer_q != '0) begin
        timer_q <= timer_q - TIMER_W'(1);
      end
      if (cmd_i.coll_inc && coll_q != '1) begin
        coll_q <= coll_q + COLL_W'(1);
      end
      head_q <= head_d;
      if (wr_en) begin
        fill_q <= fill_q + QFILL_W'(1);
      end else if (cmd_i.pop && fill_q != '0) begin
        fill_q <= fill_q - QFILL_W'(1);
      end
      // pending result moves out once the next one shows up or the item ends
      if ((cmd_i.emit && pend_valid_q) || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      bytes_q <= evt_bytes_i;
      tag_q   <= evt_tag_i;
      rnd_q   <= evt_rnd_i;
    end
    if ((cmd_i.emit && pend_valid_q) || cmd_i.flush) begin
      out_q <= '{kind: pend_q.kind, tag: pend_q.tag, bytes: pend_q.bytes,
                 coll: pend_q.coll, last: cmd_i.flush};
    end
    if (cmd_i.emit) begin
      pend_q <= '{kind: cmd_i.emit_kind, tag: head_ent_q.tag, bytes: head_ent_q.bytes,
                  coll: coll_q, last: 1'b0};
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    stat_o            = '0;
    stat_o.cmd        = cmd_q;
    stat_o.fill_zero  = (fill_q == '0);
    stat_o.fill_gt1   = (fill_q > QFILL_W'(1));
    stat_o.timer_zero = (timer_q == '0);
    stat_o.timer_le1  = (timer_q <= TIMER_W'(1));
    stat_o.busy       = busy_q;
    stat_o.try_over   = (try_q > {1'b0, max_tries_q});
    stat_o.rem_done   = rem_done;
    stat_o.emit_ok    = !pend_valid_q || out_free;
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = out_free;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QFILL_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && pend_valid_q) |-> out_free)
    else $error("result pushed while output register is held");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (fill_q != '0))
    else $error("head retired from an empty queue");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (fill_q != '0))
    else $error("media message without a head packet");
`endif

endmodule

`default_nettype wire

// File: rtl/core/cctc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cctc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire cctc_pkg::stat_t stat_i,
  output cctc_pkg::cmd_t       cmd_o
);
  import cctc_pkg::*;

  typedef enum logic [2:0] {
    SEQ_WAIT_IN,
    SEQ_APPLY,
    SEQ_COLL,
    SEQ_DIV,
    SEQ_SETTLE,
    SEQ_FLUSH
  } seq_e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_START,
    MODE_TRANSMIT,
    MODE_BACKOFF,
    MODE_FAIL
  } mode_e;

  seq_e  seq_q, seq_d;
  mode_e mode_q, mode_d;

  assign in_ready_o = (seq_q == SEQ_WAIT_IN);

  always_comb begin
    seq_d         = seq_q;
    mode_d        = mode_q;
    cmd_o         = '0;
    cmd_o.take_in = in_valid_i && (seq_q == SEQ_WAIT_IN);

    case (seq_q)
      SEQ_WAIT_IN: begin
        if (cmd_o.take_in) begin
          seq_d = SEQ_APPLY;
        end
      end

      SEQ_APPLY: begin
        case (stat_i.cmd)
          CMD_TICK: begin
            if (mode_q == MODE_TRANSMIT && stat_i.timer_le1) begin
              // last slot of the frame: report completion, retire head
              if (stat_i.emit_ok) begin
                cmd_o.tick_timer = 1'b1;
                cmd_o.emit       = 1'b1;
                cmd_o.emit_kind  = KIND_COMPLETE;
                cmd_o.pop        = 1'b1;
                if (stat_i.fill_gt1) begin
                  mode_d          = MODE_START;
                  cmd_o.try_reset = 1'b1;
                end else begin
                  mode_d = MODE_IDLE;
                end
                seq_d = SEQ_COLL;
              end
            end else begin
              if (mode_q == MODE_TRANSMIT || mode_q == MODE_BACKOFF) begin
                cmd_o.tick_timer = 1'b1;
                if (mode_q == MODE_BACKOFF && stat_i.timer_le1) begin
                  mode_d = MODE_START;
                end
              end
              seq_d = SEQ_COLL;
            end
          end
          CMD_ENQ: begin
            cmd_o.enq = 1'b1;
            if (stat_i.fill_zero) begin
              mode_d          = MODE_START;
              cmd_o.try_reset = 1'b1;
            end
            seq_d = SEQ_COLL;
          end
          CMD_MSTART: begin
            cmd_o.set_busy = 1'b1;
            seq_d          = SEQ_COLL;
          end
          CMD_MDONE, CMD_MFAIL: begin
            cmd_o.clr_busy = 1'b1;
            seq_d          = SEQ_COLL;
          end
          default: seq_d = SEQ_WAIT_IN;
        endcase
      end

      SEQ_COLL: begin
        if (stat_i.busy && mode_q == MODE_TRANSMIT) begin
          cmd_o.coll_inc  = 1'b1;
          cmd_o.div_start = 1'b1;
          mode_d          = MODE_FAIL;
          seq_d           = SEQ_DIV;
        end else begin
          seq_d = SEQ_SETTLE;
        end
      end

      SEQ_DIV: begin
        if (stat_i.rem_done) begin
          cmd_o.timer_load_rem = 1'b1;
          seq_d                = SEQ_SETTLE;
        end
      end

      SEQ_SETTLE: begin
        case (mode_q)
          MODE_FAIL: begin
            if (stat_i.emit_ok) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_FAIL;
              mode_d          = MODE_BACKOFF;
            end
          end
          MODE_BACKOFF: begin
            if (stat_i.timer_zero) begin
              mode_d = MODE_START;
            end else begin
              seq_d = SEQ_FLUSH;
            end
          end
          MODE_START: begin
            if (stat_i.busy) begin
              seq_d = SEQ_FLUSH;
            end else if (stat_i.try_over) begin
              // tries spent: drop the head silently
              cmd_o.pop = 1'b1;
              if (stat_i.fill_gt1) begin
                cmd_o.try_reset = 1'b1;
              end else begin
                mode_d = MODE_IDLE;
              end
            end else if (stat_i.emit_ok) begin
              cmd_o.emit           = 1'b1;
              cmd_o.emit_kind      = KIND_START;
              cmd_o.timer_load_len = 1'b1;
              cmd_o.try_inc        = 1'b1;
              mode_d               = MODE_TRANSMIT;
            end
          end
          default: seq_d = SEQ_FLUSH;
        endcase
      end

      SEQ_FLUSH: begin
        if (!stat_i.pend_valid) begin
          seq_d = SEQ_WAIT_IN;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          seq_d       = SEQ_WAIT_IN;
        end
      end

      default: seq_d = SEQ_WAIT_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SEQ_WAIT_IN;
      mode_q <= MODE_IDLE;
    end else begin
      seq_q  <= seq_d;
      mode_q <= mode_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/csma_cd_transmit_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// CSMA/CD transmit controller with random backoff.
// evt_i carries one event per transfer: slot tick, enqueue packet (tag and
// byte length), medium start, medium complete or medium fail, plus the random
// draw used if this event causes a collision. res_o carries zero to two media
// messages (start, fail, complete) per event; the final one has last set.
// Packets wait in a 16-entry queue; a full queue drops new packets.
// Config: cfg_we_i writes max_tries (index 0) or backoff_cap (index 1);
// write only while no event is in flight.
// Sequence: an event is taken, applied, checked for collision, then settled one
// step per cycle while the output can take a message, then flushed; an unknown
// command goes straight back to waiting. A colliding medium start also runs the
// backoff remainder (four draw bits per cycle) before the fail and backoff steps.
// Each packet dropped for spent tries costs a further settle step.
// One event is in work at a time; the last result sits in an output register
// while the next event is taken.
// Reset: idle, empty queue, collision count 0, max_tries 16, backoff_cap 10;
// queue contents are not cleared and need no clearing pass.
// A stalled receiver holds results in the output and pending registers; the
// controller waits before producing more.
module csma_cd_transmit_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cctc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cctc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cctc_evt_if.sink                             evt_i,
  cctc_res_if.source                           res_o
);
  import cctc_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    res_valid;
  logic    in_ready;

  cctc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(evt_i.valid),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  cctc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_cmd_i  (evt_i.command),
    .evt_bytes_i(evt_i.packet_bytes),
    .evt_tag_i  (evt_i.packet_tag),
    .evt_rnd_i  (evt_i.random_value),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_ready_i(res_o.ready),
    .out_valid_o(res_valid),
    .out_res_o  (res)
  );

  assign evt_i.ready           = in_ready;
  assign res_o.valid           = res_valid;
  assign res_o.media_kind      = res.kind;
  assign res_o.out_tag         = res.tag;
  assign res_o.out_bytes       = res.bytes;
  assign res_o.collision_total = res.coll;
  assign res_o.last            = res.last;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cctc_pkg::*;

  // Transmitter modes of the shadow model
  typedef enum logic [2:0] {
    TXM_IDLE,
    TXM_START,
    TXM_SEND,
    TXM_BACKOFF,
    TXM_FAIL
  } tx_mode_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTES_W-1:0] bytes;
    logic [TAG_W-1:0]   tag;
    logic [RND_W-1:0]   rnd;
  } event_t;

  // Worst settle after the last message: take, collision, divider, a queue of drops
  localparam int DRAIN_CYCLES = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cctc_evt_if evt_if ();
  cctc_res_if res_if ();

  csma_cd_transmit_controller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle percentages of sender and receiver
  int send_idle;
  int recv_idle;

  int n_errors;
  int n_queued;
  int n_taken;

  event_t  event_backlog[$];
  event_t  next_evt;
  event_t  seen_evt;
  result_t msg_due[$];
  result_t due_msg;

  // Shadow copy of the transmitter
  tx_mode_e           cur_mode;
  logic               med_busy;
  logic [TRY_W-1:0]   try_cnt;
  logic [TIMER_W-1:0] slot_left;
  logic [COLL_W-1:0]  coll_cnt;
  q_entry_t           fifo [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  fifo_head;
  logic [QFILL_W-1:0] fifo_fill;
  logic [TRIES_W-1:0] lim_tries;
  logic [CAP_W-1:0]   lim_cap;

  result_t emit_buf [2];
  int      n_emit;

  task automatic report_mismatch(input string msg);
    if (n_errors < 40) $display("%0t mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // At most two messages per event; each names the head packet
  task automatic emit_msg(input logic [KIND_W-1:0] kind);
    q_entry_t hd;
    result_t  r;
    if (n_emit < 2) begin
      hd = fifo[fifo_head];
      r.kind  = kind;
      r.tag   = hd.tag;
      r.bytes = hd.bytes;
      r.coll  = coll_cnt;
      r.last  = 1'b0;
      emit_buf[n_emit] = r;
      n_emit++;
    end
  endtask

  task automatic finish_head();
    cur_mode = TXM_IDLE;
    if (fifo_fill != '0) begin
      fifo_head = fifo_head + QPTR_W'(1);
      fifo_fill = fifo_fill - QFILL_W'(1);
    end
    if (fifo_fill != '0) begin
      cur_mode = TXM_START;
      try_cnt  = TRY_W'(1);
    end
  endtask

  // Applies one accepted event, then settles the zero-time steps and
  // queues the media messages it causes.
  task automatic apply_event(input event_t e);
    logic [TRY_W-1:0]  cap_w;
    logic [TRY_W-1:0]  modulus;
    logic [RND_W-1:0]  rem;
    logic [QPTR_W-1:0] slot;
    q_entry_t          hd;
    result_t           r;
    bit                known;
    bit                go;
    int                g;
    int                ticks;
    known  = 1'b1;
    n_emit = 0;
    case (e.cmd)
      CMD_TICK: begin
        // ignored while idle or waiting to start
        if (cur_mode == TXM_SEND || cur_mode == TXM_BACKOFF) begin
          if (slot_left != '0) slot_left = slot_left - TIMER_W'(1);
          if (slot_left == '0) begin
            if (cur_mode == TXM_SEND) begin
              emit_msg(KIND_COMPLETE);
              finish_head();
            end else begin
              cur_mode = TXM_START;
            end
          end
        end
      end
      CMD_ENQ: begin
        // a full queue drops the packet
        if (fifo_fill < QUEUE_DEPTH) begin
          slot = fifo_head + fifo_fill[QPTR_W-1:0];
          if (fifo_fill == '0) begin
            cur_mode = TXM_START;
            try_cnt  = TRY_W'(1);
          end
          fifo[slot] = {e.tag, e.bytes};
          fifo_fill  = fifo_fill + QFILL_W'(1);
        end
      end
      CMD_MSTART: med_busy = 1'b1;
      CMD_MDONE, CMD_MFAIL: med_busy = 1'b0;
      default: known = 1'b0;
    endcase
    if (known) begin
      // another station started while we send: collision
      if (med_busy && cur_mode == TXM_SEND) begin
        if (coll_cnt != '1) coll_cnt = coll_cnt + COLL_W'(1);
        cur_mode = TXM_FAIL;
        cap_w    = lim_cap;
        modulus  = (cap_w < try_cnt) ? cap_w : try_cnt;
        if (modulus == '0) begin
          slot_left = '0;
        end else begin
          rem       = e.rnd % modulus;
          slot_left = rem[TIMER_W-1:0];
        end
      end
      go = 1'b1;
      for (g = 0; go && g < 4 * QUEUE_DEPTH + 8; g++) begin
        if (cur_mode == TXM_FAIL) begin
          emit_msg(KIND_FAIL);
          cur_mode = TXM_BACKOFF;
        end else if (cur_mode == TXM_BACKOFF && slot_left == '0) begin
          cur_mode = TXM_START;
        end else if (cur_mode == TXM_START && !med_busy) begin
          if (try_cnt > lim_tries) begin
            finish_head();
          end else begin
            emit_msg(KIND_START);
            hd        = fifo[fifo_head];
            ticks     = 1 + (8 * int'(hd.bytes)) / SLOT_BITS;
            slot_left = ticks[TIMER_W-1:0];
            try_cnt   = try_cnt + TRY_W'(1);
            cur_mode  = TXM_SEND;
          end
        end else begin
          go = 1'b0;
        end
      end
      for (g = 0; g < n_emit; g++) begin
        r       = emit_buf[g];
        r.last  = (g == n_emit - 1);
        msg_due = {msg_due, r};
      end
    end
  endtask

  task automatic queue_event(input logic [CMD_W-1:0] cmd, input logic [31:0] b,
                             input logic [31:0] t, input logic [31:0] rn);
    event_t e;
    e.cmd   = cmd;
    e.bytes = b[BYTES_W-1:0];
    e.tag   = t[TAG_W-1:0];
    e.rnd   = rn[RND_W-1:0];
    event_backlog = {event_backlog, e};
    n_queued++;
  endtask

  // Mostly short packets so transfers finish in a few ticks
  task automatic queue_packet();
    int          r;
    logic [31:0] b;
    r = $urandom_range(99);
    if (r < 75) b = $urandom_range(191);
    else if (r < 85) b = $urandom_range(1) ? BYTES_MAX : 0;
    else b = $urandom;
    queue_event(CMD_ENQ, b, $urandom, $urandom);
  endtask

  // Traffic of packets, ticks and medium activity, with some noise
  task automatic gen_random(input int n);
    int          done;
    int          r;
    int          k;
    logic [31:0] rc;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // burst, may overflow the queue
        k = $urandom_range(18, 3);
        repeat (k) queue_packet();
        done += k;
      end else if (r < 38) begin
        queue_packet();
        done++;
      end else if (r < 68) begin
        k = $urandom_range(3, 1);
        repeat (k) queue_event(CMD_TICK, $urandom, $urandom, $urandom);
        done += k;
      end else if (r < 80) begin
        queue_event(CMD_MSTART, $urandom, $urandom, $urandom);
        done++;
      end else if (r < 94) begin
        queue_event(r[0] ? CMD_MDONE : CMD_MFAIL, $urandom, $urandom, $urandom);
        done++;
      end else begin
        rc = $urandom;
        queue_event(rc[CMD_W-1:0], $urandom, $urandom, $urandom);
        if (rc[CMD_W-1:0] <= CMD_MFAIL) done++;
      end
    end
  endtask

  // Writes both registers; called only with no event in flight
  task automatic configure(input logic [TRIES_W-1:0] tries, input logic [CAP_W-1:0] cap);
    logic [CFG_DATA_W-1:0] upper;
    upper = CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_TRIES;
    cfg_data_i <= tries;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BACKOFF_CAP;
    cfg_data_i <= {upper[CFG_DATA_W-1:CAP_W], cap};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lim_tries = tries;
    lim_cap   = cap;
  endtask

  task automatic drain();
    while (n_taken != n_queued || msg_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Event driver: predicts on each transfer, presents the next item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      evt_if.valid <= 1'b0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        seen_evt = {evt_if.command, evt_if.packet_bytes, evt_if.packet_tag,
                    evt_if.random_value};
        apply_event(seen_evt);
        n_taken++;
      end
      if (!evt_if.valid || evt_if.ready) begin
        if (event_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
          next_evt = event_backlog[0];
          event_backlog.delete(0);
          evt_if.valid        <= 1'b1;
          evt_if.command      <= next_evt.cmd;
          evt_if.packet_bytes <= next_evt.bytes;
          evt_if.packet_tag   <= next_evt.tag;
          evt_if.random_value <= next_evt.rnd;
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  // Message monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (msg_due.size() == 0) begin
          report_mismatch($sformatf("unexpected message kind %0d tag %0h",
                                    res_if.media_kind, res_if.out_tag));
        end else begin
          due_msg = msg_due[0];
          msg_due.delete(0);
          if (res_if.media_kind !== due_msg.kind)
            report_mismatch($sformatf("media_kind got %0d expected %0d",
                                      res_if.media_kind, due_msg.kind));
          if (res_if.out_tag !== due_msg.tag)
            report_mismatch($sformatf("out_tag got %0h expected %0h",
                                      res_if.out_tag, due_msg.tag));
          if (res_if.out_bytes !== due_msg.bytes)
            report_mismatch($sformatf("out_bytes got %0d expected %0d",
                                      res_if.out_bytes, due_msg.bytes));
          if (res_if.collision_total !== due_msg.coll)
            report_mismatch($sformatf("collision_total got %0d expected %0d",
                                      res_if.collision_total, due_msg.coll));
          if (res_if.last !== due_msg.last)
            report_mismatch($sformatf("last got %0b expected %0b",
                                      res_if.last, due_msg.last));
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    logic [TRIES_W-1:0] rt;
    logic [CAP_W-1:0]   rcap;
    int                 i;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    evt_if.valid        = 1'b0;
    evt_if.command      = '0;
    evt_if.packet_bytes = '0;
    evt_if.packet_tag   = '0;
    evt_if.random_value = '0;
    res_if.ready        = 1'b0;
    n_errors  = 0;
    n_queued  = 0;
    n_taken   = 0;
    cur_mode  = TXM_IDLE;
    med_busy  = 1'b0;
    try_cnt   = TRY_W'(1);
    slot_left = '0;
    coll_cnt  = '0;
    fifo_head = '0;
    fifo_fill = '0;
    lim_tries = MAX_TRIES_RST;
    lim_cap   = BACKOFF_CAP_RST;
    for (i = 0; i < QUEUE_DEPTH; i++) fifo[i] = '0;
    send_idle = 30;
    recv_idle = 49;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle tick, unknown codes, start while not sending,
    // full queue, extreme lengths/tags/draws, collision and backoff.
    queue_event(CMD_TICK, 0, 0, 0);
    queue_event(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_event(3'd6, 0, 0, 0);
    queue_event(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_event(CMD_MSTART, 0, 0, 0);
    // medium busy: the first 16 wait, the last one finds the queue full
    queue_event(CMD_ENQ, BYTES_MAX, 32'hFFFF, 0);
    queue_event(CMD_ENQ, 0, 0, 32'hFFFF);
    for (i = 0; i < 15; i++) queue_packet();
    queue_event(CMD_MFAIL, 0, 0, 0);
    queue_event(CMD_MSTART, 0, 0, 32'hFFFF);
    queue_event(CMD_TICK, 0, 0, 0);
    queue_event(CMD_MDONE, 0, 0, 0);
    drain();

    configure(8'd1, 4'd15);
    gen_random(110);
    drain();

    send_idle = 49;
    recv_idle = 30;
    configure(8'd255, 4'd1);
    gen_random(110);
    drain();

    // zero backoff modulus
    configure(8'd3, 4'd0);
    gen_random(60);
    drain();

    send_idle = 0;
    recv_idle = 0;
    // every packet dropped silently
    rcap = CAP_W'($urandom_range(15, 1));
    configure(8'd0, rcap);
    gen_random(30);
    drain();

    rt   = TRIES_W'($urandom_range(254, 2));
    rcap = CAP_W'($urandom_range(14, 2));
    configure(rt, rcap);
    gen_random(110);
    drain();

    // Collision count saturation needs far more collisions than this run has.
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
